FILE: sv/luhn_pkg.sv
// ----------------------------------------------------------------------------
// luhn_pkg - shared types and constants for the card number check
// Widths of the card number, its decimal form, state and brand codes.
// ----------------------------------------------------------------------------
`default_nettype none

package luhn_pkg;

  localparam int NUM_W   = 54;           // binary card number width
  localparam int NDIG    = 17;           // decimal digits that 54 bits can need
  localparam int BCD_W   = 4 * NDIG;     // packed BCD width
  localparam int STEP_W  = 6;            // step counter width (holds NUM_W - 1)
  localparam int CNT_W   = 5;            // digit count width

  localparam logic [STEP_W-1:0] CONV_LAST  = STEP_W'(NUM_W - 1);
  localparam logic [STEP_W-1:0] DIGIT_LAST = STEP_W'(NDIG - 1);

  localparam logic [CNT_W-1:0] MIN_LEN   = CNT_W'(13);
  localparam logic [CNT_W-1:0] MAX_LEN   = CNT_W'(16);
  localparam logic [CNT_W-1:0] PAIR3_LEN = CNT_W'(15);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(NDIG);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CONV  = 3'b010,
    ST_DIGIT = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    BRAND_NONE  = 3'd0,   // length or checksum failed
    BRAND_PAIR3 = 3'd1,   // fifteen digits, leading pair 34..37
    BRAND_PAIR5 = 3'd2,   // leading pair 51..55
    BRAND_LEAD4 = 3'd3,   // leading digit 4
    BRAND_OTHER = 3'd4    // any other prefix
  } brand_t;

endpackage

`default_nettype wire

FILE: sv/card_number_luhn_check.sv
// ----------------------------------------------------------------------------
// card_number_luhn_check - digit-serial Luhn mod-10 card number check
// Bit-serial binary to BCD conversion, then one decimal digit per cycle (the last
// can stall on the output) for the digit count, the Luhn sum and the brand prefix.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid / in_ready    | card_number
//  out     | output    | out_valid / out_ready  | length_ok, digit_count,
//          |           |                        | checksum_ok, brand_code
//
//  Sequence: after the input transfer come the 54 shift/add-3 steps of the BCD
//    converter, then the 17 steps of the digit pass; out_valid rises after the
//    last digit step. The next input can transfer once the block is back in idle.
//  Only one item is in flight; in_ready is high while the block is idle, which
//    includes the time a finished result waits in the output register.
//  Stalls: if the previous result is still untaken when the digit pass ends,
//    the last step holds until out_ready frees the output register.
//  Reset: rst (synchronous) returns to idle and drops out_valid; in_ready is
//    low while rst is high.
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_check (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [luhn_pkg::NUM_W-1:0] card_number,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          length_ok,
  output logic [4:0]                    digit_count,
  output logic                          checksum_ok,
  output logic [2:0]                    brand_code
);

  luhn_pkg::state_t               state;
  logic [luhn_pkg::STEP_W-1:0]    step;
  logic [luhn_pkg::NUM_W-1:0]     bin;   // binary shift register, MSB first out
  logic [luhn_pkg::BCD_W-1:0]     bcd;   // BCD accumulator, then digit shifter
  logic [luhn_pkg::BCD_W-1:0]     bcd_adj;

  // running digit-pass results
  logic [3:0]                     sum;   // Luhn sum modulo ten
  logic [luhn_pkg::CNT_W-1:0]     count; // digits up to the highest nonzero one
  logic [3:0]                     lead;  // highest nonzero digit so far
  logic [3:0]                     low;   // digit just below lead
  logic [3:0]                     prev;  // digit of the previous step

  logic [3:0]                     sum_next;
  logic [luhn_pkg::CNT_W-1:0]     count_next;
  logic [3:0]                     lead_next;
  logic [3:0]                     low_next;

  logic [3:0]                     dig;
  logic [4:0]                     dbl;
  logic [3:0]                     weighted;
  logic [4:0]                     sum_raw;
  logic                           last_digit;
  logic                           out_free;
  logic                           finish;

  logic                           len_ok_w;
  logic                           luhn_ok_w;
  luhn_pkg::brand_t               brand_w;

  assign in_ready   = (state == luhn_pkg::ST_IDLE) && !rst;
  assign out_free   = !out_valid || out_ready;
  assign last_digit = (state == luhn_pkg::ST_DIGIT) && (step == luhn_pkg::DIGIT_LAST);
  assign finish     = last_digit && out_free;

  // double dabble: add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < luhn_pkg::NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // one decimal digit per cycle unless the last one stalls, least significant first
  always_comb begin
    dig = bcd[3:0];
    dbl = {dig, 1'b0};
    if (step[0]) begin
      // odd places from the right are doubled; above 9 take the digit sum
      weighted = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
    end else begin
      weighted = dig;
    end
    sum_raw  = {1'b0, sum} + {1'b0, weighted};
    sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];

    count_next = count;
    lead_next  = lead;
    low_next   = low;
    if (dig != 4'd0) begin
      count_next = luhn_pkg::CNT_W'(step) + luhn_pkg::CNT_W'(1);
      lead_next  = dig;
      low_next   = (step == '0) ? 4'd0 : prev;
    end
  end

  // final flags from the values the last digit step produces
  always_comb begin
    len_ok_w  = (count_next >= luhn_pkg::MIN_LEN) && (count_next <= luhn_pkg::MAX_LEN);
    luhn_ok_w = (sum_next == 4'd0);
    brand_w   = luhn_pkg::BRAND_NONE;
    if (len_ok_w && luhn_ok_w) begin
      if ((count_next == luhn_pkg::PAIR3_LEN) && (lead_next == 4'd3) &&
          (low_next >= 4'd4) && (low_next <= 4'd7)) begin
        brand_w = luhn_pkg::BRAND_PAIR3;
      end else if ((lead_next == 4'd5) && (low_next >= 4'd1) && (low_next <= 4'd5)) begin
        brand_w = luhn_pkg::BRAND_PAIR5;
      end else if (lead_next == 4'd4) begin
        brand_w = luhn_pkg::BRAND_LEAD4;
      end else begin
        brand_w = luhn_pkg::BRAND_OTHER;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= luhn_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        luhn_pkg::ST_IDLE: begin
          if (in_valid) begin
            state <= luhn_pkg::ST_CONV;
            step  <= '0;
          end
        end
        luhn_pkg::ST_CONV: begin
          if (step == luhn_pkg::CONV_LAST) begin
            state <= luhn_pkg::ST_DIGIT;
            step  <= '0;
          end else begin
            step <= step + luhn_pkg::STEP_W'(1);
          end
        end
        luhn_pkg::ST_DIGIT: begin
          if (finish) begin
            state <= luhn_pkg::ST_IDLE;
            step  <= '0;
          end else if (!last_digit) begin
            step <= step + luhn_pkg::STEP_W'(1);
          end
        end
        default: begin
          state <= luhn_pkg::ST_IDLE;
          step  <= '0;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bin <= card_number;
      bcd <= '0;
    end else if (state == luhn_pkg::ST_CONV) begin
      {bcd, bin} <= {bcd_adj[luhn_pkg::BCD_W-2:0], bin, 1'b0};
    end else if ((state == luhn_pkg::ST_DIGIT) && !last_digit) begin
      bcd <= {4'd0, bcd[luhn_pkg::BCD_W-1:4]};
    end

    if (state == luhn_pkg::ST_CONV) begin
      // digit pass starts clean: zero input reads as the single digit 0
      sum   <= 4'd0;
      count <= luhn_pkg::CNT_W'(1);
      lead  <= 4'd0;
      low   <= 4'd0;
      prev  <= 4'd0;
    end else if ((state == luhn_pkg::ST_DIGIT) && !last_digit) begin
      sum   <= sum_next;
      count <= count_next;
      lead  <= lead_next;
      low   <= low_next;
      prev  <= dig;
    end

    if (finish) begin
      length_ok   <= len_ok_w;
      digit_count <= count_next;
      checksum_ok <= luhn_ok_w;
      brand_code  <= brand_w;
    end
  end

`ifndef SYNTH
  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == luhn_pkg::ST_CONV) && (step == '0))
    else $error("transfer in did not start the conversion");

  a_brand_needs_pass: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (brand_code != luhn_pkg::BRAND_NONE)) |-> (length_ok && checksum_ok))
    else $error("brand code given on a failed check");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((digit_count != '0) && (digit_count <= luhn_pkg::MAX_CNT)))
    else $error("digit count out of range");

  a_len_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length_ok == ((digit_count >= luhn_pkg::MIN_LEN) &&
                                 (digit_count <= luhn_pkg::MAX_LEN))))
    else $error("length flag disagrees with digit count");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && last_digit) |=> (state == luhn_pkg::ST_DIGIT))
    else $error("result finished over an untaken one");
`endif

endmodule

`default_nettype wire
